// ----- sv/bdq_pkg.sv -----
// Shared types and codes for the bounded deque core.
// Used by bdq_cell, bounded_deque_core and bdq_checker; depends on nothing.
package bdq_pkg;

  localparam int WORD_W        = 32;
  localparam int DEPTH_DEFAULT = 16;
  localparam int COUNT_OUT_W   = 5;

  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [2:0] FUNC_POP_BACK   = 3'd3;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CMD_HOLD       = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [WORD_W-1:0] data;
  } request_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic [COUNT_OUT_W-1:0]   count;
    logic                     is_empty;
    logic                     is_full;
  } result_t;

endpackage

// ----- sv/bdq_cell.sv -----
// One storage cell of the deque chain: a word and an occupancy bit.
// Takes its neighbours' contents on shifts; depends on bdq_pkg.
module bdq_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  bdq_pkg::cell_cmd_t                cmd,
  input  logic signed [bdq_pkg::WORD_W-1:0] push_word,
  input  logic signed [bdq_pkg::WORD_W-1:0] prev_word,
  input  logic                              prev_valid,
  input  logic signed [bdq_pkg::WORD_W-1:0] next_word,
  input  logic                              next_valid,
  output logic signed [bdq_pkg::WORD_W-1:0] word,
  output logic                              valid
);

  logic signed [bdq_pkg::WORD_W-1:0] word_next;
  logic                              valid_next;

  always_comb begin
    word_next  = word;
    valid_next = valid;
    case (cmd)
      bdq_pkg::CMD_PUSH_FRONT: begin
        word_next  = prev_word;
        valid_next = prev_valid;
      end
      bdq_pkg::CMD_PUSH_BACK: begin
        // first free cell takes the item
        if (!valid && prev_valid) begin
          word_next  = push_word;
          valid_next = 1'b1;
        end
      end
      bdq_pkg::CMD_POP_FRONT: begin
        word_next  = next_word;
        valid_next = next_valid;
      end
      bdq_pkg::CMD_POP_BACK: begin
        if (valid && !next_valid) begin
          valid_next = 1'b0;
        end
      end
      default: begin
        word_next  = word;
        valid_next = valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ----- sv/bounded_deque_core.sv -----
// Top level of the bounded deque: control, entry count and the cell chain.
// Depends on bdq_pkg and bdq_cell.
//
// Each item is taken at the accepting edge; in the cycle after it the chain
// has changed and the result is shown with done high. busy is high then, so
// no new item is taken before the last is through. Cell 0 holds the front;
// a front push or pop moves the whole row by one place, a back push fills
// the first free cell, a back pop frees the last occupied cell, and the rear
// word is picked from the last occupied cell. The result is presented for
// exactly one cycle and cannot be held off by the receiver.
module bounded_deque_core #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bdq_pkg::request_t request,
  output logic              done,
  output bdq_pkg::result_t  result
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_REPORT = 2'b10
  } state_t;

  state_t                            state;
  logic [CW-1:0]                     count;
  logic [1:0]                        status;
  bdq_pkg::cell_cmd_t                cmd;
  logic                              accept;
  logic                              is_full_now;
  logic                              is_empty_now;
  logic signed [bdq_pkg::WORD_W-1:0] cell_word  [DEPTH];
  logic                              cell_valid [DEPTH];
  logic signed [bdq_pkg::WORD_W-1:0] rear_word;

  assign accept       = start && (state == ST_IDLE);
  assign is_full_now  = (count == CW'(DEPTH));
  assign is_empty_now = (count == '0);

  always_comb begin
    cmd = bdq_pkg::CMD_HOLD;
    if (accept) begin
      case (request.func)
        bdq_pkg::FUNC_PUSH_FRONT: if (!is_full_now)  cmd = bdq_pkg::CMD_PUSH_FRONT;
        bdq_pkg::FUNC_PUSH_BACK:  if (!is_full_now)  cmd = bdq_pkg::CMD_PUSH_BACK;
        bdq_pkg::FUNC_POP_FRONT:  if (!is_empty_now) cmd = bdq_pkg::CMD_POP_FRONT;
        bdq_pkg::FUNC_POP_BACK:   if (!is_empty_now) cmd = bdq_pkg::CMD_POP_BACK;
        default:                  cmd = bdq_pkg::CMD_HOLD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      status <= bdq_pkg::STATUS_DONE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_REPORT;
            case (request.func)
              bdq_pkg::FUNC_PUSH_FRONT, bdq_pkg::FUNC_PUSH_BACK: begin
                if (is_full_now) begin
                  status <= bdq_pkg::STATUS_FULL;
                end else begin
                  status <= bdq_pkg::STATUS_DONE;
                  count  <= count + CW'(1);
                end
              end
              bdq_pkg::FUNC_POP_FRONT, bdq_pkg::FUNC_POP_BACK: begin
                if (is_empty_now) begin
                  status <= bdq_pkg::STATUS_EMPTY;
                end else begin
                  status <= bdq_pkg::STATUS_DONE;
                  count  <= count - CW'(1);
                end
              end
              default: status <= bdq_pkg::STATUS_DONE;
            endcase
          end
        end
        ST_REPORT: state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // Cell chain: cell 0 holds the front word
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [bdq_pkg::WORD_W-1:0] prev_word;
    logic                              prev_valid;
    logic signed [bdq_pkg::WORD_W-1:0] next_word;
    logic                              next_valid;

    if (i == 0) begin : g_head
      assign prev_word  = request.data;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_word  = cell_word[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_word  = cell_word[i];
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_word  = cell_word[i+1];
      assign next_valid = cell_valid[i+1];
    end

    bdq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .push_word  (request.data),
      .prev_word  (prev_word),
      .prev_valid (prev_valid),
      .next_word  (next_word),
      .next_valid (next_valid),
      .word       (cell_word[i]),
      .valid      (cell_valid[i])
    );
  end

  // Rear word: the only occupied cell whose neighbour is free
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_valid[i] && ((i == DEPTH - 1) || !cell_valid[(i + 1) % DEPTH])) begin
        rear_word = rear_word | cell_word[i];
      end
    end
  end

  assign busy = (state == ST_REPORT);
  assign done = (state == ST_REPORT);

  always_comb begin
    result.status      = status;
    result.front_value = cell_valid[0] ? cell_word[0] : '0;
    result.rear_value  = rear_word;
    result.count       = bdq_pkg::COUNT_OUT_W'(count);
    result.is_empty    = is_empty_now;
    result.is_full     = is_full_now;
  end

endmodule

// ----- sv/bdq_checker.sv -----
// Port-level checks for bounded_deque_core, attached by bind.
// Depends on bdq_pkg.
module bdq_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input bdq_pkg::request_t request,
  input logic              done,
  input bdq_pkg::result_t  result
);

  // every accepted item gives its result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("no result after accepted item");

  // no new item can be taken while a result is shown
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result shown while idle");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.is_empty |-> result.front_value == '0 && result.rear_value == '0
      && result.count == '0 && !result.is_full)
    else $error("empty deque reports data");

  // the item shown is the request taken at the accepting edge
  a_refused_full: assert property (@(posedge clk) disable iff (rst)
    done && result.status == bdq_pkg::STATUS_FULL |-> result.is_full
      && ($past(request.func) == bdq_pkg::FUNC_PUSH_FRONT
        || $past(request.func) == bdq_pkg::FUNC_PUSH_BACK))
    else $error("push refused but deque not full");

  a_refused_empty: assert property (@(posedge clk) disable iff (rst)
    done && result.status == bdq_pkg::STATUS_EMPTY |-> result.is_empty)
    else $error("pop refused but deque not empty");

endmodule

bind bounded_deque_core bdq_checker u_bdq_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);
